FILE: hdl/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] NBUSY_NONE = 2'd0;
	localparam logic [1:0] NBUSY_ONE  = 2'd1;
	localparam logic [1:0] NBUSY_MANY = 2'd2;

	typedef struct packed {
		logic       go;
		logic       found;
		logic [1:0] nbusy;
	} tok_ctl_t;

	typedef struct packed {
		logic load;
		logic dec;
	} cell_cmd_t;

endpackage

FILE: hdl/srtf_cell.sv
`timescale 1ns / 1ps

module srtf_cell #(
	parameter int IDX_W     = 4,
	parameter int TIME_BITS = 16,
	parameter int CELL_IDX  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srtf_pkg::cell_cmd_t  cmd,
	input  logic [IDX_W-1:0]     cmd_idx,
	input  logic [TIME_BITS-1:0] ld_arr,
	input  logic [TIME_BITS-1:0] ld_burst,
	input  logic [TIME_BITS-1:0] now,
	input  srtf_pkg::tok_ctl_t   ctl_in,
	input  logic [TIME_BITS-1:0] rem_in,
	input  logic [IDX_W-1:0]     idx_in,
	input  logic [TIME_BITS-1:0] arr_in,
	input  logic [TIME_BITS-1:0] burst_in,
	output srtf_pkg::tok_ctl_t   ctl_out,
	output logic [TIME_BITS-1:0] rem_out,
	output logic [IDX_W-1:0]     idx_out,
	output logic [TIME_BITS-1:0] arr_out,
	output logic [TIME_BITS-1:0] burst_out
);
	import srtf_pkg::*;

	logic                 loaded_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] burst_q;
	tok_ctl_t             ctl_q;
	logic [TIME_BITS-1:0] rem_out_q;
	logic [IDX_W-1:0]     idx_out_q;
	logic [TIME_BITS-1:0] arr_out_q;
	logic [TIME_BITS-1:0] burst_out_q;

	logic       hit;
	logic       busy;
	logic       cand;
	logic       take;
	logic [1:0] nbusy_nxt;

	assign hit  = (cmd_idx == IDX_W'(CELL_IDX));
	assign busy = loaded_q && (rem_q != '0);
	assign cand = busy && (arr_q <= now);
	assign take = cand && (!ctl_in.found || (rem_q < rem_in));

	always_comb begin
		nbusy_nxt = ctl_in.nbusy;
		if (busy && ctl_in.nbusy != NBUSY_MANY) begin
			nbusy_nxt = ctl_in.nbusy + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			rem_q    <= '0;
		end else if (cmd.load && hit) begin
			loaded_q <= 1'b1;
			rem_q    <= ld_burst;
		end else if (cmd.dec && hit) begin
			rem_q <= rem_q - TIME_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			arr_q   <= ld_arr;
			burst_q <= ld_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.go    <= ctl_in.go;
			ctl_q.found <= ctl_in.found || take;
			ctl_q.nbusy <= nbusy_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_out_q   <= rem_q;
			idx_out_q   <= IDX_W'(CELL_IDX);
			arr_out_q   <= arr_q;
			burst_out_q <= burst_q;
		end else begin
			rem_out_q   <= rem_in;
			idx_out_q   <= idx_in;
			arr_out_q   <= arr_in;
			burst_out_q <= burst_in;
		end
	end

	assign ctl_out   = ctl_q;
	assign rem_out   = rem_out_q;
	assign idx_out   = idx_out_q;
	assign arr_out   = arr_out_q;
	assign burst_out = burst_out_q;

endmodule

FILE: hdl/srtf_scheduler.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_stall   | func, slot, arrival_time, burst_length
// out     | output    | out_valid, out_stall | chosen_slot, idle, finished, waiting_time,
//         |           |                      | turnaround_time, tick_time, all_done
//
// A load word produces no result.
// In a tick word the search token steps through the row of cells one cell per cycle;
// when it leaves the row the winner is captured and its slot updated, and the result
// is then formed in the output register once that register is free.
// Reset clears every slot, the time counter and the output valid flag.
// A stalled output holds its word; a new input word is accepted meanwhile, but a tick
// waits for the output register to free before it completes.
`timescale 1ns / 1ps

module srtf_scheduler #(
	parameter int MAX_PROCS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [3:0]  slot,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  chosen_slot,
	output logic        idle,
	output logic        finished,
	output logic [15:0] waiting_time,
	output logic [15:0] turnaround_time,
	output logic [15:0] tick_time,
	output logic        all_done
);
	import srtf_pkg::*;

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]           state_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] fin_q;

	logic                 st_found_q;
	logic [IDX_W-1:0]     st_idx_q;
	logic [TIME_BITS-1:0] st_turn_q;
	logic [TIME_BITS-1:0] st_burst_q;
	logic                 st_done_q;
	logic                 st_all_q;
	logic [TIME_BITS-1:0] st_tick_q;

	logic        out_valid_q;
	logic [3:0]  chosen_q;
	logic        idle_q;
	logic        finished_q;
	logic [15:0] waiting_q;
	logic [15:0] turn_q;
	logic [15:0] tick_q;
	logic        all_done_q;

	tok_ctl_t             ch_ctl   [MAX_PROCS+1];
	logic [TIME_BITS-1:0] ch_rem   [MAX_PROCS+1];
	logic [IDX_W-1:0]     ch_idx   [MAX_PROCS+1];
	logic [TIME_BITS-1:0] ch_arr   [MAX_PROCS+1];
	logic [TIME_BITS-1:0] ch_burst [MAX_PROCS+1];
	logic [MAX_PROCS:0]   go_vec;

	logic                 accept;
	logic                 load_hit;
	logic                 tick_start;
	logic                 sweep_end;
	logic                 out_free;
	cell_cmd_t            cmd;
	logic [IDX_W-1:0]     cmd_idx;
	logic [TIME_BITS-1:0] ld_arr;
	logic [TIME_BITS-1:0] ld_burst;
	logic [TIME_BITS-1:0] turn_nxt;
	logic [TIME_BITS-1:0] wait_nxt;
	logic                 done_nxt;
	logic                 all_nxt;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign load_hit   = (int'(slot) < MAX_PROCS);
	assign tick_start = accept && (func == FUNC_TICK);
	assign sweep_end  = (state_q == ST_SWEEP) && ch_ctl[MAX_PROCS].go;
	assign out_free   = !out_valid_q || !out_stall;

	assign ld_arr   = TIME_BITS'(arrival_time);
	assign ld_burst = TIME_BITS'(burst_length);

	assign cmd.load = accept && (func == FUNC_LOAD) && load_hit;
	assign cmd.dec  = sweep_end && ch_ctl[MAX_PROCS].found;
	assign cmd_idx  = cmd.load ? IDX_W'(slot) : ch_idx[MAX_PROCS];

	assign ch_ctl[0]   = '{go: tick_start, found: 1'b0, nbusy: NBUSY_NONE};
	assign ch_rem[0]   = '0;
	assign ch_idx[0]   = '0;
	assign ch_arr[0]   = '0;
	assign ch_burst[0] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
			srtf_cell #(
				.IDX_W     (IDX_W),
				.TIME_BITS (TIME_BITS),
				.CELL_IDX  (gi)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.cmd_idx   (cmd_idx),
				.ld_arr    (ld_arr),
				.ld_burst  (ld_burst),
				.now       (now_q),
				.ctl_in    (ch_ctl[gi]),
				.rem_in    (ch_rem[gi]),
				.idx_in    (ch_idx[gi]),
				.arr_in    (ch_arr[gi]),
				.burst_in  (ch_burst[gi]),
				.ctl_out   (ch_ctl[gi+1]),
				.rem_out   (ch_rem[gi+1]),
				.idx_out   (ch_idx[gi+1]),
				.arr_out   (ch_arr[gi+1]),
				.burst_out (ch_burst[gi+1])
			);
		end
		for (gi = 0; gi <= MAX_PROCS; gi++) begin : g_go
			assign go_vec[gi] = ch_ctl[gi].go;
		end
	endgenerate

	always_comb begin
		turn_nxt = '0;
		if (fin_q >= ch_arr[MAX_PROCS]) begin
			turn_nxt = fin_q - ch_arr[MAX_PROCS];
		end
		done_nxt = ch_ctl[MAX_PROCS].found && (ch_rem[MAX_PROCS] == TIME_BITS'(1));
		all_nxt  = (ch_ctl[MAX_PROCS].nbusy == NBUSY_NONE) ||
			((ch_ctl[MAX_PROCS].nbusy == NBUSY_ONE) && done_nxt);
		wait_nxt = '0;
		if (st_turn_q >= st_burst_q) begin
			wait_nxt = st_turn_q - st_burst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick_start) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (sweep_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (sweep_end && now_q != TMAX) begin
			now_q <= now_q + TIME_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (tick_start) begin
			fin_q <= (now_q != TMAX) ? now_q + TIME_BITS'(1) : now_q;
		end
		if (sweep_end) begin
			st_found_q <= ch_ctl[MAX_PROCS].found;
			st_idx_q   <= ch_idx[MAX_PROCS];
			st_turn_q  <= turn_nxt;
			st_burst_q <= ch_burst[MAX_PROCS];
			st_done_q  <= done_nxt;
			st_all_q   <= all_nxt;
			st_tick_q  <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			chosen_q   <= st_found_q ? 4'(st_idx_q) : 4'd0;
			idle_q     <= !st_found_q;
			finished_q <= st_done_q;
			waiting_q  <= st_done_q ? 16'(wait_nxt) : 16'd0;
			turn_q     <= st_done_q ? 16'(st_turn_q) : 16'd0;
			tick_q     <= 16'(st_tick_q);
			all_done_q <= st_all_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign chosen_slot     = chosen_q;
	assign idle            = idle_q;
	assign finished        = finished_q;
	assign waiting_time    = waiting_q;
	assign turnaround_time = turn_q;
	assign tick_time       = tick_q;
	assign all_done        = all_done_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(go_vec) <= 1)
		else $error("More than one search token in the row of cells.");

	a_token_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ch_ctl[MAX_PROCS].go |-> state_q == ST_SWEEP)
		else $error("Search token left the row outside a sweep.");

	a_winner_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(sweep_end && ch_ctl[MAX_PROCS].found) |-> ch_rem[MAX_PROCS] != '0)
		else $error("Chosen slot has no remaining work.");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> now_q >= $past(now_q))
		else $error("Time counter went backwards.");

	a_finish_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && finished_q) |-> !idle_q)
		else $error("Idle tick reported a finished process.");

endmodule

FILE: tb/srtf_schedule_check.sv
`timescale 1ns / 1ps

module srtf_schedule_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        func,
	input  logic [3:0]  slot,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_length,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  chosen_slot,
	input  logic        idle,
	input  logic        finished,
	input  logic [15:0] waiting_time,
	input  logic [15:0] turnaround_time,
	input  logic [15:0] tick_time,
	input  logic        all_done,
	output int          fail_count,
	output int          outstanding
);
	import srtf_pkg::*;

	typedef struct packed {
		logic [3:0]  slot;
		logic        idle;
		logic        finished;
		logic [15:0] waiting;
		logic [15:0] turnaround;
		logic [15:0] tick_time;
		logic        all_done;
	} tick_report_t;

	logic [15:0]  arrival_tbl [16];
	logic [15:0]  burst_tbl [16];
	logic [15:0]  remaining_tbl [16];
	logic [15:0]  loaded;
	logic [15:0]  clock_now;
	tick_report_t report_q [$];

	task automatic load_slot(input logic [3:0] s, input logic [15:0] a, input logic [15:0] b);
		arrival_tbl[s] = a;
		burst_tbl[s] = b;
		remaining_tbl[s] = b;
		loaded[s] = 1'b1;
	endtask

	// Runs one tick of shortest-remaining-time-first; ties go to the lowest slot.
	task automatic run_tick(output tick_report_t r);
		int          pick;
		int          i;
		logic [15:0] finish_at;
		logic [15:0] turn;
		r = '0;
		pick = -1;
		for (i = 0; i < 16; i++)
			if (loaded[i] && remaining_tbl[i] != 16'd0 && arrival_tbl[i] <= clock_now &&
			    (pick < 0 || remaining_tbl[i] < remaining_tbl[pick]))
				pick = i;
		r.idle = 1'b1;
		r.tick_time = clock_now;
		if (pick >= 0) begin
			remaining_tbl[pick] = remaining_tbl[pick] - 16'd1;
			r.slot = 4'(pick);
			r.idle = 1'b0;
			if (remaining_tbl[pick] == 16'd0) begin
				finish_at = (clock_now == 16'hFFFF) ? clock_now : clock_now + 16'd1;
				turn = (finish_at >= arrival_tbl[pick]) ? finish_at - arrival_tbl[pick] : 16'd0;
				r.finished = 1'b1;
				r.turnaround = turn;
				r.waiting = (turn >= burst_tbl[pick]) ? turn - burst_tbl[pick] : 16'd0;
			end
		end
		r.all_done = 1'b1;
		for (i = 0; i < 16; i++)
			if (loaded[i] && remaining_tbl[i] != 16'd0)
				r.all_done = 1'b0;
		if (clock_now != 16'hFFFF)
			clock_now = clock_now + 16'd1;
	endtask

	task automatic compare(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("t=%0t %s: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Handshakes are sampled on the falling edge, where they hold the values
	// that the next rising edge will see.
	always @(negedge clk or negedge arst_n) begin : watch
		tick_report_t want;
		if (!arst_n) begin
			loaded = '0;
			clock_now = '0;
			foreach (remaining_tbl[i])
				remaining_tbl[i] = '0;
			report_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					$display("t=%0t result word with no tick pending: expected none, actual slot %0d",
						$time, chosen_slot);
					fail_count++;
				end else begin
					want = report_q.pop_front();
					compare("chosen_slot", 16'(want.slot), 16'(chosen_slot));
					compare("idle", 16'(want.idle), 16'(idle));
					compare("finished", 16'(want.finished), 16'(finished));
					compare("waiting_time", want.waiting, waiting_time);
					compare("turnaround_time", want.turnaround, turnaround_time);
					compare("tick_time", want.tick_time, tick_time);
					compare("all_done", 16'(want.all_done), 16'(all_done));
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_LOAD) begin
					load_slot(slot, arrival_time, burst_length);
				end else begin
					run_tick(want);
					report_q.push_back(want);
				end
			end
			outstanding = report_q.size();
		end
	end

endmodule

FILE: tb/tb_srtf_scheduler.sv
`timescale 1ns / 1ps

module tb_srtf_scheduler;
	import srtf_pkg::*;

	localparam int IDLE_PCT     = 15;
	localparam int WORD_TARGET  = 1300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = FUNC_LOAD;
	logic [3:0]  slot = '0;
	logic [15:0] arrival_time = '0;
	logic [15:0] burst_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  chosen_slot;
	logic        idle;
	logic        finished;
	logic [15:0] waiting_time;
	logic [15:0] turnaround_time;
	logic [15:0] tick_time;
	logic        all_done;
	int          fail_count;
	int          outstanding;
	int          words_sent = 0;
	int          ticks_sent = 0;
	logic        steady = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	srtf_scheduler u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.slot            (slot),
		.arrival_time    (arrival_time),
		.burst_length    (burst_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chosen_slot     (chosen_slot),
		.idle            (idle),
		.finished        (finished),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time),
		.tick_time       (tick_time),
		.all_done        (all_done)
	);

	srtf_schedule_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.slot            (slot),
		.arrival_time    (arrival_time),
		.burst_length    (burst_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chosen_slot     (chosen_slot),
		.idle            (idle),
		.finished        (finished),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time),
		.tick_time       (tick_time),
		.all_done        (all_done),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic send_word(input logic f, input logic [3:0] s, input logic [15:0] a,
	                         input logic [15:0] b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		slot <= s;
		arrival_time <= a;
		burst_length <= b;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		words_sent++;
		if (f == FUNC_TICK)
			ticks_sent++;
	endtask

	task automatic load_word(input logic [3:0] s, input logic [15:0] a, input logic [15:0] b);
		send_word(FUNC_LOAD, s, a, b);
	endtask

	// The payload of a tick word is ignored, so it is filled at random.
	task automatic tick_word();
		send_word(FUNC_TICK, 4'($urandom_range(15)), 16'($urandom), 16'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL srtf_scheduler");
		$finish;
	end

	initial begin : stimulus
		int          episode;
		int          k;
		int          work;
		bit          paused;
		logic [15:0] b;
		episode = 0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing loaded, then a tie between two ready slots, a zero burst and a
		// slot that never arrives.
		tick_word();
		load_word(4'd0, 16'd1, 16'd3);
		load_word(4'd15, 16'd0, 16'd3);
		load_word(4'd5, 16'd0, 16'd0);
		load_word(4'd9, 16'hFFFF, 16'hFFFF);
		repeat (3) tick_word();
		// A later arrival and a reload that restarts a slot which has waited.
		load_word(4'd3, 16'd6, 16'd1);
		load_word(4'd15, 16'd2, 16'd2);
		repeat (4) tick_word();
		load_word(4'd9, 16'd0, 16'd1);
		repeat (2) tick_word();
		// A long job is pre-empted by a short one that arrives later.
		load_word(4'd12, 16'd0, 16'hFFFF);
		tick_word();
		load_word(4'd4, 16'd11, 16'd2);
		repeat (3) tick_word();
		load_word(4'd12, 16'd0, 16'd1);
		repeat (2) tick_word();
		drain_results();

		while (words_sent < WORD_TARGET) begin
			steady <= (words_sent >= 400 && words_sent < 650);
			if (episode % 10 == 9) begin
				for (int s = 0; s < 16; s++)
					load_word(4'(s), 16'(ticks_sent), 16'd1);
				repeat (18) tick_word();
			end else if ($urandom_range(99) < 80) begin
				k = $urandom_range(4, 1);
				work = 0;
				repeat (k) begin
					b = ($urandom_range(99) < 5) ? 16'($urandom_range(65535, 1))
					                             : 16'($urandom_range(8, 1));
					load_word(4'($urandom_range(15)), 16'(ticks_sent + $urandom_range(6)), b);
					work += (b > 16'd8) ? 8 : int'(b);
					if ($urandom_range(1) == 1)
						tick_word();
				end
				repeat (work + $urandom_range(3)) tick_word();
			end else begin
				send_word(1'($urandom_range(1)), 4'($urandom_range(15)), 16'($urandom),
					16'($urandom_range(65535, 1)));
			end
			episode++;
			if (words_sent >= 800 && !paused) begin
				drain_results();
				paused = 1'b1;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS srtf_scheduler");
		else
			$display("FAIL srtf_scheduler");
		$finish;
	end

endmodule

FILE: files.f
hdl/srtf_pkg.sv
hdl/srtf_cell.sv
hdl/srtf_scheduler.sv
tb/srtf_schedule_check.sv
tb/tb_srtf_scheduler.sv
